>>> rtl/gbci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbci_pkg: shared types and constants of the gyro calibrate/integrate block
// Item layout between the front end and the back end, widths, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package gbci_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TARGET_W = 26;
  localparam int ANGLE_W  = 32;
  localparam int SUM_W    = 24;
  localparam int SCALE_W  = 24;
  localparam int TOL_W    = 31;
  localparam int CFG_W    = 31;

  // register indexes of the configuration port
  localparam logic [0:0] REG_ANGLE_SCALE = 1'b0;
  localparam logic [0:0] REG_TARGET_TOL  = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd1503238;
  localparam logic [TOL_W-1:0]   TOL_RESET   = 31'd131072;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TARGET_W-1:0] target_t;
  typedef logic signed [ANGLE_W-1:0]  angle_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // 999 degrees in Q16.16
  localparam angle_t END_ANGLE_RESET = 32'sd65470464;
  localparam angle_t ANGLE_MAX       = 32'sh7fff_ffff;
  localparam angle_t ANGLE_MIN       = 32'sh8000_0000;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TARGET = 1'b1
  } op_e;

  typedef struct packed {
    op_e     op;
    sample_t sample_x;
    sample_t sample_y;
    sample_t sample_z;
    target_t target_angle;
  } item_t;

endpackage

>>> rtl/gbci_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbci_fifo: item queue between front end and back end
// Small first-word-fall-through queue; DEPTH is a power of two, 2 to 16.
// ----------------------------------------------------------------------------
module gbci_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_vld_i,
  output logic             wr_rdy_o,
  input  gbci_pkg::item_t  wr_item_i,
  output logic             rd_vld_o,
  input  logic             rd_rdy_i,
  output gbci_pkg::item_t  rd_item_o
);

  localparam int PTR_W = $clog2(DEPTH);

  gbci_pkg::item_t  mem_q [DEPTH];
  logic [PTR_W:0]   wptr_q, wptr_d;
  logic [PTR_W:0]   rptr_q, rptr_d;
  logic             full;
  logic             push;
  logic             pop;

  // full when pointers differ only in the wrap bit
  assign full     = (wptr_q[PTR_W] != rptr_q[PTR_W]) &&
                    (wptr_q[PTR_W-1:0] == rptr_q[PTR_W-1:0]);
  assign wr_rdy_o = !full;
  assign rd_vld_o = (wptr_q != rptr_q);
  assign push     = wr_vld_i && !full;
  assign pop      = rd_rdy_i && rd_vld_o;

  assign rd_item_o = mem_q[rptr_q[PTR_W-1:0]];

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop  ? rptr_q + 1'b1 : rptr_q;
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  // store the beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q[PTR_W-1:0]] <= wr_item_i;
    end
  end

endmodule

>>> rtl/gbci_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbci_front: input side of the gyro block
// Takes stream beats, unpacks the sample and target fields and classifies
// each beat as a rate sample or a set-target command for the queue.
// ----------------------------------------------------------------------------
module gbci_front (
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] sample_x, [31:16] sample_y, [47:32] sample_z,
  // [73:48] target_angle, [79:74] zero
  input  logic [79:0]      s_axis_tdata,
  // [0] mode
  input  logic [0:0]       s_axis_tuser,
  output logic             wr_vld_o,
  input  logic             wr_rdy_i,
  output gbci_pkg::item_t  wr_item_o
);

  // take a beat whenever the queue has room
  assign s_axis_tready = wr_rdy_i;
  assign wr_vld_o      = s_axis_tvalid;

  // unpack and classify
  always_comb begin
    wr_item_o.op           = s_axis_tuser[0] ? gbci_pkg::OP_TARGET : gbci_pkg::OP_SAMPLE;
    wr_item_o.sample_x     = s_axis_tdata[15:0];
    wr_item_o.sample_y     = s_axis_tdata[31:16];
    wr_item_o.sample_z     = s_axis_tdata[47:32];
    wr_item_o.target_angle = s_axis_tdata[73:48];
  end

endmodule

>>> rtl/gbci_bias_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbci_bias_div: bias divider
// Divides the three calibration sums by CAL_SAMPLES, truncating toward zero.
// Reciprocal multiply on the magnitudes, all axes in parallel, in registered steps:
// load magnitude, multiply, restore sign.
// ----------------------------------------------------------------------------
module gbci_bias_div #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  gbci_pkg::sum_t     sum_i  [3],
  output logic               rdy_o,
  output gbci_pkg::sample_t  bias_o [3]
);

  localparam int SUM_W    = gbci_pkg::SUM_W;
  localparam int SAMPLE_W = gbci_pkg::SAMPLE_W;
  // up to 127 sums of 16-bit samples stay below 2^(SUM_W-1) in magnitude
  localparam int MAG_W    = SUM_W - 1;
  // seven extra fraction bits keep the quotient exact for divisors up to 127
  localparam int SHIFT    = MAG_W + 7;
  localparam int RCP_W    = SHIFT + 1;
  localparam int PROD_W   = MAG_W + RCP_W;
  localparam int QUO_W    = SAMPLE_W + 1;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'((2 ** SHIFT + CAL_SAMPLES - 1) / CAL_SAMPLES);

  logic                mag_vld_q;
  logic                quo_vld_q;
  logic                rdy_q;
  logic                neg_q    [3];
  logic [MAG_W-1:0]    mag_q    [3];
  logic [QUO_W-1:0]    quo_q    [3];
  gbci_pkg::sample_t   bias_q   [3];

  logic [PROD_W-1:0]   prod     [3];

  // magnitude times the rounded-up reciprocal
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a] = PROD_W'(mag_q[a]) * PROD_W'(RECIP);
    end
  end

  // advance the stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_vld_q <= 1'b0;
      quo_vld_q <= 1'b0;
      rdy_q     <= 1'b0;
    end else begin
      mag_vld_q <= start_i;
      quo_vld_q <= mag_vld_q;
      if (quo_vld_q) begin
        rdy_q <= 1'b1;
      end
    end
  end

  // load magnitudes, take the quotient, restore the sign
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (start_i) begin
        neg_q[a] <= sum_i[a][SUM_W-1];
        mag_q[a] <= sum_i[a][SUM_W-1] ? MAG_W'(-sum_i[a]) : MAG_W'(sum_i[a]);
      end
      if (mag_vld_q) begin
        quo_q[a] <= prod[a][SHIFT+QUO_W-1:SHIFT];
      end
      if (quo_vld_q) begin
        bias_q[a] <= neg_q[a] ? SAMPLE_W'(-quo_q[a]) : SAMPLE_W'(quo_q[a]);
      end
    end
  end

  assign rdy_o = rdy_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      bias_o[a] = bias_q[a];
    end
  end

endmodule

>>> rtl/gbci_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbci_back: execution side of the gyro block
// Holds calibration sums, biases, angles and end angle; runs one item per
// cycle unless stalled, then checks the target window and drives the result beat.
// ----------------------------------------------------------------------------
module gbci_back #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [gbci_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         rd_vld_i,
  output logic                         rd_rdy_o,
  input  gbci_pkg::item_t              rd_item_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [31:0] angle_x, [63:32] angle_y, [95:64] angle_z
  output logic [95:0]                  m_axis_tdata,
  // [0] calibrated, [1] at_target
  output logic [1:0]                   m_axis_tuser
);

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W = gbci_pkg::SUM_W;

  logic [gbci_pkg::SCALE_W-1:0] scale_q;
  logic [gbci_pkg::TOL_W-1:0]   tol_q;

  gbci_pkg::sum_t     sum_q [3], sum_d [3];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               cal_q, cal_d;
  gbci_pkg::angle_t   acc_q [3], acc_d [3];
  gbci_pkg::angle_t   end_q, end_d;

  logic               e_vld_q;
  gbci_pkg::angle_t   e_acc_q [3];
  gbci_pkg::angle_t   e_end_q;
  logic               e_cal_q;

  logic               m_vld_q;
  gbci_pkg::angle_t   m_acc_q [3];
  logic               m_cal_q;
  logic               m_hit_q;

  gbci_pkg::sample_t  samp [3];
  gbci_pkg::sample_t  bias [3];
  logic               bias_rdy;
  logic               div_start;
  logic               o_ready;
  logic               e_ready;
  logic               stall;
  logic               pop;
  logic signed [32:0] dz;
  logic [32:0]        mag;
  logic               hit;

  function automatic gbci_pkg::angle_t sat32(logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? gbci_pkg::ANGLE_MIN : gbci_pkg::ANGLE_MAX;
    end
    return v[31:0];
  endfunction

  // bias-corrected sample times scale, rounded half up to Q16.16, accumulated
  function automatic gbci_pkg::angle_t integ(gbci_pkg::angle_t acc, gbci_pkg::sample_t s,
                                             gbci_pkg::sample_t b,
                                             logic [gbci_pkg::SCALE_W-1:0] scale);
    logic signed [16:0] d;
    logic signed [42:0] p;
    logic signed [42:0] r;
    logic signed [32:0] t;
    d = 17'(s) - 17'(b);
    p = 43'(d) * $signed({19'b0, scale});
    r = p + 43'sd32768;
    t = 33'(acc) + 33'($signed(r[42:16]));
    return sat32(t);
  endfunction

  gbci_bias_div #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_bias_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_d),
    .rdy_o   (bias_rdy),
    .bias_o  (bias)
  );

  assign samp[0] = rd_item_i.sample_x;
  assign samp[1] = rd_item_i.sample_y;
  assign samp[2] = rd_item_i.sample_z;

  // pipeline flow: output register, then execute stage
  assign o_ready  = !m_vld_q || m_axis_tready;
  assign e_ready  = !e_vld_q || o_ready;
  assign stall    = (rd_item_i.op == gbci_pkg::OP_SAMPLE) && cal_q && !bias_rdy;
  assign pop      = rd_vld_i && e_ready && !stall;
  assign rd_rdy_o = pop;

  // execute one item against the state
  always_comb begin
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    cal_d     = cal_q;
    acc_d     = acc_q;
    end_d     = end_q;
    div_start = 1'b0;
    if (pop) begin
      case (rd_item_i.op)
        gbci_pkg::OP_TARGET: begin
          end_d = sat32(33'(rd_item_i.target_angle) + 33'(acc_q[2]));
        end
        gbci_pkg::OP_SAMPLE: begin
          if (!cal_q) begin
            for (int a = 0; a < 3; a++) begin
              sum_d[a] = sum_q[a] + SUM_W'(samp[a]);
            end
            cnt_d = cnt_q + 1'b1;
            if (cnt_d == CNT_W'(CAL_SAMPLES)) begin
              cal_d     = 1'b1;
              div_start = 1'b1;
            end
          end else begin
            for (int a = 0; a < 3; a++) begin
              acc_d[a] = integ(acc_q[a], samp[a], bias[a], scale_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // target window check on the snapshot
  always_comb begin
    dz  = 33'(e_end_q) - 33'(e_acc_q[2]);
    mag = dz[32] ? 33'(-dz) : 33'(dz);
    hit = (mag < {2'b00, tol_q});
  end

  // state, configuration and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= gbci_pkg::SCALE_RESET;
      tol_q   <= gbci_pkg::TOL_RESET;
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= '0;
        acc_q[a] <= '0;
      end
      cnt_q   <= '0;
      cal_q   <= 1'b0;
      end_q   <= gbci_pkg::END_ANGLE_RESET;
      e_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gbci_pkg::REG_ANGLE_SCALE: scale_q <= cfg_data_i[gbci_pkg::SCALE_W-1:0];
          gbci_pkg::REG_TARGET_TOL:  tol_q   <= cfg_data_i[gbci_pkg::TOL_W-1:0];
          default: ;
        endcase
      end
      sum_q <= sum_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      cal_q <= cal_d;
      end_q <= end_d;
      if (pop) begin
        e_vld_q <= 1'b1;
      end else if (o_ready) begin
        e_vld_q <= 1'b0;
      end
      if (e_vld_q && o_ready) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // snapshot and result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      e_acc_q <= acc_d;
      e_end_q <= end_d;
      e_cal_q <= cal_d;
    end
    if (e_vld_q && o_ready) begin
      m_acc_q <= e_acc_q;
      m_cal_q <= e_cal_q;
      m_hit_q <= hit;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {m_acc_q[2], m_acc_q[1], m_acc_q[0]};
  assign m_axis_tuser  = {m_hit_q, m_cal_q};

  // checks on the calibration sequence
  a_bias_after_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bias_rdy |-> cal_q)
    else $error("bias ready before calibration finished");

  a_bias_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cal_q) |-> !bias_rdy)
    else $error("bias ready in the cycle calibration finished");

  a_angles_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cal_q |-> (acc_q[0] == '0) && (acc_q[1] == '0) && (acc_q[2] == '0))
    else $error("angles moved during calibration");

  a_count_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_q |-> (cnt_q == CNT_W'(CAL_SAMPLES)))
    else $error("calibration count off at completion");

  a_no_early_integrate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cal_q && (rd_item_i.op == gbci_pkg::OP_SAMPLE)) |-> bias_rdy)
    else $error("sample integrated before bias was ready");

endmodule

>>> rtl/gyro_bias_calibrate_integrate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_integrate: gyro bias calibration and angle integration
// An accepted beat passes the queue, execute and output registers to its result.
// Throughput: one beat per cycle, set by the execute stage, while the result
// port takes beats. Once, when calibration completes, samples wait for the
// bias divide (reciprocal multiply); set-target beats go on only while no waiting sample is ahead of them.
// Reset: sums, count and angles cleared, end angle 999 degrees, registers to defaults.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_integrate #(
  parameter int CAL_SAMPLES = 100,  // 1 to 127
  parameter int FIFO_DEPTH  = 4     // power of two, 2 to 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [gbci_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [15:0] sample_x, [31:16] sample_y, [47:32] sample_z,
  // [73:48] target_angle, [79:74] zero
  input  logic [79:0]                 s_axis_tdata,
  // [0] mode
  input  logic [0:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [31:0] angle_x, [63:32] angle_y, [95:64] angle_z
  output logic [95:0]                 m_axis_tdata,
  // [0] calibrated, [1] at_target
  output logic [1:0]                  m_axis_tuser
);

  logic             wr_vld;
  logic             wr_rdy;
  gbci_pkg::item_t  wr_item;
  logic             rd_vld;
  logic             rd_rdy;
  gbci_pkg::item_t  rd_item;

  gbci_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .wr_vld_o      (wr_vld),
    .wr_rdy_i      (wr_rdy),
    .wr_item_o     (wr_item)
  );

  gbci_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_vld_i  (wr_vld),
    .wr_rdy_o  (wr_rdy),
    .wr_item_i (wr_item),
    .rd_vld_o  (rd_vld),
    .rd_rdy_i  (rd_rdy),
    .rd_item_o (rd_item)
  );

  gbci_back #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .rd_vld_i      (rd_vld),
    .rd_rdy_o      (rd_rdy),
    .rd_item_i     (rd_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
